### rtl/pcrg_pkg.sv
// shared types and constants for the pump channel runtime guard
package pcrg_pkg;

    localparam int MASK_W = 4;
    localparam int SESS_W = 16;
    localparam int TOTAL_W = 32;

    localparam logic [15:0] MAX_RUNTIME_RESET = 16'd3600;
    localparam logic [15:0] SESS_MAX = 16'hFFFF;

    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_AUTO = 2'd1;
    localparam logic [1:0] MODE_LOCKED = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam logic [2:0] ADDR_MAX_RUNTIME = 3'd0;

    typedef enum logic [2:0] {
        FUNC_START = 3'd0,
        FUNC_STOP  = 3'd1,
        FUNC_MODE  = 3'd2,
        FUNC_QUERY = 3'd3,
        FUNC_TICK  = 3'd4
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [1:0]  new_mode;
        logic        force_req;
        logic [3:0]  pump;
    } cmd_t;

    typedef struct packed {
        logic                running;
        logic [1:0]          mode;
        logic                forced;
        logic [SESS_W-1:0]   session;
        logic [TOTAL_W-1:0]  total;
        logic                timeout;
        logic                start_ok;
    } lane_t;

    typedef struct packed {
        logic [MASK_W-1:0]   timeout_mask;
        logic [MASK_W-1:0]   relay_mask;
        logic [TOTAL_W-1:0]  total_seconds;
        logic [SESS_W-1:0]   session_seconds;
        logic                was_forced;
        logic [1:0]          pump_mode;
        logic                is_running;
        logic                invalid_pump;
        logic                ok;
    } result_t;

endpackage

### rtl/pcrg_cfg.sv
// apb register block holding the runtime limit
module pcrg_cfg
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] max_runtime
);
    import pcrg_pkg::*;

    logic [15:0] max_runtime_reg;
    logic [15:0] max_runtime_next;
    logic        hit;

    assign hit = (paddr == ADDR_MAX_RUNTIME);

    always_comb
    begin
        max_runtime_next = max_runtime_reg;
        if (psel && penable && pwrite && hit)
        begin
            max_runtime_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_runtime_reg <= MAX_RUNTIME_RESET;
        end
        else
        begin
            max_runtime_reg <= max_runtime_next;
        end
    end

    assign prdata = hit ? {16'd0, max_runtime_reg} : 32'd0;
    assign pready = 1'b1;
    assign max_runtime = max_runtime_reg;

endmodule

### rtl/pcrg_lane.sv
// state and next-state logic of one pump
module pcrg_lane
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               sel,
    input  pcrg_pkg::cmd_t     cmd,
    input  logic [15:0]        max_runtime,
    output pcrg_pkg::lane_t    stat
);
    import pcrg_pkg::*;

    logic               run_reg;
    logic               run_next;
    logic [1:0]         mode_reg;
    logic [1:0]         mode_next;
    logic               forced_reg;
    logic               forced_next;
    logic [SESS_W-1:0]  sess_reg;
    logic [SESS_W-1:0]  sess_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [SESS_W-1:0]  sess_inc;
    logic [SESS_W-1:0]  add_sess;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] total_sat;
    logic               start_ok;
    logic               timeout;

    assign sess_inc = (sess_reg == SESS_MAX) ? sess_reg : sess_reg + 16'd1;
    assign add_sess = (cmd.func == FUNC_TICK) ? sess_inc : sess_reg;
    assign sum = {1'b0, total_reg} + {17'd0, add_sess};
    assign total_sat = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    assign start_ok = run_reg || !((mode_reg == MODE_LOCKED) && !cmd.force_req);

    always_comb
    begin
        run_next = run_reg;
        mode_next = mode_reg;
        forced_next = forced_reg;
        sess_next = sess_reg;
        total_next = total_reg;
        timeout = 1'b0;
        unique case (cmd.func)
            FUNC_START:
            begin
                if (sel && !run_reg && start_ok)
                begin
                    run_next = 1'b1;
                    forced_next = cmd.force_req;
                    sess_next = '0;
                end
            end
            FUNC_STOP:
            begin
                if (sel && run_reg)
                begin
                    total_next = total_sat;
                    run_next = 1'b0;
                    sess_next = '0;
                end
            end
            FUNC_MODE:
            begin
                if (sel && (cmd.new_mode != MODE_RESERVED))
                begin
                    mode_next = cmd.new_mode;
                end
            end
            FUNC_TICK:
            begin
                if (run_reg)
                begin
                    if (sess_inc > max_runtime)
                    begin
                        total_next = total_sat;
                        run_next = 1'b0;
                        sess_next = '0;
                        timeout = 1'b1;
                    end
                    else
                    begin
                        sess_next = sess_inc;
                    end
                end
            end
            FUNC_QUERY: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            mode_reg <= MODE_MANUAL;
            forced_reg <= 1'b0;
            sess_reg <= '0;
            total_reg <= '0;
        end
        else if (step)
        begin
            run_reg <= run_next;
            mode_reg <= mode_next;
            forced_reg <= forced_next;
            sess_reg <= sess_next;
            total_reg <= total_next;
        end
    end

    assign stat.running = run_next;
    assign stat.mode = mode_next;
    assign stat.forced = forced_next;
    assign stat.session = sess_next;
    assign stat.total = total_next;
    assign stat.timeout = timeout;
    assign stat.start_ok = start_ok;

endmodule

### rtl/pump_channel_runtime_guard_top.sv
// top level: command register, pump lanes, result register and apb port
// Each beat carries one command (start, stop, set mode, query) for one pump
// or a one-second tick, and yields exactly one result beat. A command enters
// an input register, the bank of per-pump registers and the result are
// updated together when the command moves on, and the result sits in an
// output register until taken. One beat is accepted per clock unless the
// output stalls. The rate is set by the update of the per-pump register
// bank, which every beat reads and writes. The runtime limit lives at byte
// address 0 of the apb port.
module pump_channel_runtime_guard_top
#(
    parameter int PUMPS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pump[3:0], force_req[4], new_mode[6:5], zero[7]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ok[0], invalid_pump[1], is_running[2], pump_mode[4:3], was_forced[5],
    // session_seconds[21:6], total_seconds[53:22], relay_mask[57:54],
    // timeout_mask[61:58], zero[63:62]
    output logic [63:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pcrg_pkg::*;

    localparam int IDX_W = (PUMPS > 1) ? $clog2(PUMPS) : 1;
    localparam int MASK_USED = (PUMPS < MASK_W) ? PUMPS : MASK_W;
    localparam logic [4:0] PUMP_LIMIT = 5'(PUMPS);

    logic              in_vld_reg;
    logic              in_vld_next;
    cmd_t              cmd_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    result_t           res_reg;
    result_t           res_next;
    logic              advance;
    logic              pump_valid;
    logic [IDX_W-1:0]  idx;
    logic [15:0]       max_runtime;
    logic [MASK_W-1:0] relay_mask;
    logic [MASK_W-1:0] timeout_mask;
    lane_t             lane_stat [PUMPS];
    logic [PUMPS-1:0]  lane_sel;

    pcrg_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_runtime (max_runtime)
    );

    assign advance = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign pump_valid = ({1'b0, cmd_reg.pump} < PUMP_LIMIT);
    assign idx = cmd_reg.pump[IDX_W-1:0];

    for (genvar g = 0; g < PUMPS; g++)
    begin : g_lane
        assign lane_sel[g] = pump_valid && (idx == IDX_W'(g));

        pcrg_lane u_lane
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .step        (advance),
            .sel         (lane_sel[g]),
            .cmd         (cmd_reg),
            .max_runtime (max_runtime),
            .stat        (lane_stat[g])
        );
    end

    for (genvar m = 0; m < MASK_W; m++)
    begin : g_mask
        if (m < MASK_USED)
        begin : g_used
            assign relay_mask[m] = lane_stat[m].running;
            assign timeout_mask[m] = lane_stat[m].timeout;
        end
        else
        begin : g_unused
            assign relay_mask[m] = 1'b0;
            assign timeout_mask[m] = 1'b0;
        end
    end

    always_comb
    begin
        res_next = '0;
        res_next.invalid_pump = !pump_valid;
        res_next.relay_mask = relay_mask;
        res_next.timeout_mask = timeout_mask;
        if (pump_valid)
        begin
            res_next.ok = (cmd_reg.func == FUNC_START) && lane_stat[idx].start_ok;
            res_next.is_running = lane_stat[idx].running;
            res_next.pump_mode = lane_stat[idx].mode;
            res_next.was_forced = lane_stat[idx].forced;
            res_next.session_seconds = lane_stat[idx].session;
            res_next.total_seconds = lane_stat[idx].total;
        end
    end

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_axis_tready)
        begin
            in_vld_next = s_axis_tvalid;
        end
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg.func <= func_t'(s_axis_tuser);
            cmd_reg.pump <= s_axis_tdata[3:0];
            cmd_reg.force_req <= s_axis_tdata[4];
            cmd_reg.new_mode <= s_axis_tdata[6:5];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata = {2'b00, res_reg};

`ifndef SYNTHESIS
    // only a tick may stop pumps on the runtime limit
    a_timeout_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (cmd_reg.func != FUNC_TICK) |=> (res_reg.timeout_mask == '0))
        else $error("timeout mask set outside a tick");

    // a pump stopped by the limit is no longer energized
    a_timeout_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> ((res_reg.timeout_mask & res_reg.relay_mask) == '0))
        else $error("timed out pump still energized");

    a_ok_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(res_reg.ok && res_reg.invalid_pump))
        else $error("ok reported for invalid pump");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.invalid_pump |->
        (res_reg.total_seconds == '0) && (res_reg.session_seconds == '0) &&
        !res_reg.is_running)
        else $error("invalid pump result carries pump state");

    // the result register never loses a beat under backpressure
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !m_axis_tready |=> out_vld_reg && $stable(res_reg))
        else $error("stalled result changed");
`endif

endmodule
